// ===== rtl/servo_feedback_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// Servo feedback receiver assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// They use the clk and rst names of the including module.
// ----------------------------------------------------------------------------
`ifndef SERVO_FEEDBACK_FRAME_RECEIVER_ASSERT_SVH
`define SERVO_FEEDBACK_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sffr assertion failed");
// next-cycle implication
`define SFFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sffr assertion failed");
`else
`define SFFR_ASSERT_NOW(lbl, ante, cons)
`define SFFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/sffr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo feedback receiver package
// Frame constants, result codes and payload types.
// ----------------------------------------------------------------------------
package sffr_pkg;

  typedef logic [7:0]        byte_t;
  typedef logic [2:0]        status_t;
  typedef logic [2:0]        qty_t;
  typedef logic signed [31:0] reading_t;

  localparam byte_t HDR_BYTE  = 8'h7A;
  localparam byte_t TAIL_BYTE = 8'h7B;

  localparam int FRAME_LEN   = 9;
  localparam int CHECKED_LEN = 7;
  localparam int STORE_DEPTH = FRAME_LEN - 1;
  localparam int COUNT_W     = 4;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  // count at which the next byte closes the frame
  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_LEN - 1);

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVO_A = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVO_B = 1'b1;

  localparam byte_t SERVO_A_RESET = 8'd1;
  localparam byte_t SERVO_B_RESET = 8'd2;

  // frame status
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_TAIL  = 3'd1;
  localparam status_t ST_CHECK = 3'd2;
  localparam status_t ST_ADDR  = 3'd3;
  localparam status_t ST_TYPE  = 3'd4;

  // feedback quantities
  localparam byte_t QTY_SPEED      = 8'd0;
  localparam byte_t QTY_MULTI_TURN = 8'd1;
  localparam byte_t QTY_ANGLE      = 8'd2;
  localparam byte_t QTY_ACCEL      = 8'd3;
  localparam byte_t QTY_VOLTAGE    = 8'd4;

endpackage

// ===== rtl/sffr_if.sv =====
// ----------------------------------------------------------------------------
// Servo feedback receiver channels
// Valid/ready channels for received bytes and decoded feedback results.
// ----------------------------------------------------------------------------
interface sffr_byte_if;
  logic            valid;
  logic            ready;
  sffr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sffr_fb_if;
  logic               valid;
  logic               ready;
  sffr_pkg::status_t  frame_status;
  logic               servo_slot;
  sffr_pkg::qty_t     quantity;
  sffr_pkg::reading_t reading;

  modport source (output valid, output frame_status, output servo_slot,
                  output quantity, output reading, input ready);
  modport sink   (input valid, input frame_status, input servo_slot,
                  input quantity, input reading, output ready);
endinterface

// ===== rtl/servo_feedback_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Servo feedback frame receiver
// Parses 9-byte servo feedback frames from a UART byte stream.
// ----------------------------------------------------------------------------
// Bytes enter on rx, one per transfer, and one byte can be taken every clock.
// While hunting, anything but the header 0x7A is dropped. A frame is header,
// address, type, four big-endian data bytes, an XOR check over the first
// seven bytes and the tail 0x7B; a header byte inside a frame is plain data.
// The ninth byte yields one result on fb on the following cycle: status
// (tail, then check, then address, then type are tested), slot, quantity and
// value; rejected frames carry zero in every field but the status. Single
// angle and voltage return the low 16 bits zero-extended. The result sits in
// an output register; bytes that do not close a frame are taken even while it
// waits, and only a ninth byte waits on rx until that register is free or is
// being emptied in the same cycle. Addresses for the two slots must be written
// via cfg_write/cfg_index/cfg_data while the receiver is idle; the block does
// not enforce it. If both match, slot 0 wins. Any ninth byte restarts hunting.
// ----------------------------------------------------------------------------
`include "servo_feedback_frame_receiver_assert.svh"

module servo_feedback_frame_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sffr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  sffr_pkg::byte_t                     cfg_data,
  sffr_byte_if.sink                           rx,
  sffr_fb_if.source                           fb
);

  // configuration
  sffr_pkg::byte_t servo_a_address;
  sffr_pkg::byte_t servo_b_address;

  // frame collection
  logic [sffr_pkg::COUNT_W-1:0] byte_count;
  logic [sffr_pkg::COUNT_W-1:0] byte_count_next;
  sffr_pkg::byte_t              frame_store [sffr_pkg::STORE_DEPTH];

  // result register
  logic               out_valid;
  sffr_pkg::status_t  out_status;
  logic               out_slot;
  sffr_pkg::qty_t     out_qty;
  sffr_pkg::reading_t out_reading;

  logic in_xfer;
  logic closing;      // the byte at the input would finish a frame
  logic judge_xfer;
  logic store_wr;

  // judgement of the complete frame
  sffr_pkg::byte_t    chk;
  sffr_pkg::status_t  j_status;
  logic               j_slot;
  sffr_pkg::qty_t     j_qty;
  sffr_pkg::reading_t j_reading;
  logic [31:0]        word;
  logic               match_a;
  logic               match_b;

  // counts above the last one cannot occur, but act like it
  assign closing    = (byte_count >= sffr_pkg::LAST_COUNT);
  assign rx.ready   = !closing || !out_valid || fb.ready;
  assign in_xfer    = rx.valid && rx.ready;
  assign judge_xfer = in_xfer && closing;
  assign store_wr   = in_xfer && !closing &&
                      ((byte_count != '0) || (rx.rx_byte == sffr_pkg::HDR_BYTE));

  always_comb begin
    byte_count_next = byte_count;
    if (in_xfer) begin
      if (closing) begin
        byte_count_next = '0;
      end else if (byte_count != '0) begin
        byte_count_next = byte_count + 1'b1;
      end else if (rx.rx_byte == sffr_pkg::HDR_BYTE) begin
        byte_count_next = sffr_pkg::COUNT_W'(1);
      end
    end
  end

  always_comb begin
    chk = '0;
    for (int i = 0; i < sffr_pkg::CHECKED_LEN; i++) begin
      chk = chk ^ frame_store[i];
    end
  end

  always_comb begin
    match_a   = (frame_store[1] == servo_a_address);
    match_b   = (frame_store[1] == servo_b_address);
    word      = {frame_store[3], frame_store[4], frame_store[5], frame_store[6]};
    j_status  = sffr_pkg::ST_OK;
    j_slot    = 1'b0;
    j_qty     = '0;
    j_reading = '0;
    if (rx.rx_byte != sffr_pkg::TAIL_BYTE) begin
      j_status = sffr_pkg::ST_TAIL;
    end else if (chk != frame_store[7]) begin
      j_status = sffr_pkg::ST_CHECK;
    end else if (!match_a && !match_b) begin
      j_status = sffr_pkg::ST_ADDR;
    end else if (frame_store[2] > sffr_pkg::QTY_VOLTAGE) begin
      j_status = sffr_pkg::ST_TYPE;
    end else begin
      j_slot = !match_a;
      j_qty  = frame_store[2][2:0];
      if ((frame_store[2] == sffr_pkg::QTY_ANGLE) ||
          (frame_store[2] == sffr_pkg::QTY_VOLTAGE)) begin
        j_reading = {16'h0000, word[15:0]};
      end else begin
        j_reading = word;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_a_address <= sffr_pkg::SERVO_A_RESET;
      servo_b_address <= sffr_pkg::SERVO_B_RESET;
      byte_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          sffr_pkg::REG_SERVO_A: servo_a_address <= cfg_data;
          sffr_pkg::REG_SERVO_B: servo_b_address <= cfg_data;
          default: ;
        endcase
      end
      byte_count <= byte_count_next;
      if (judge_xfer) begin
        out_valid <= 1'b1;
      end else if (fb.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: frame bytes and result fields
  always_ff @(posedge clk) begin
    if (store_wr) begin
      frame_store[byte_count[sffr_pkg::STORE_IDX_W-1:0]] <= rx.rx_byte;
    end
    if (judge_xfer) begin
      out_status  <= j_status;
      out_slot    <= j_slot;
      out_qty     <= j_qty;
      out_reading <= j_reading;
    end
  end

  assign fb.valid        = out_valid;
  assign fb.frame_status = out_status;
  assign fb.servo_slot   = out_slot;
  assign fb.quantity     = out_qty;
  assign fb.reading      = out_reading;

  // checks
  `SFFR_ASSERT_NOW(a_count_range, 1'b1, byte_count <= sffr_pkg::LAST_COUNT)
  `SFFR_ASSERT_NEXT(a_close_result, judge_xfer, out_valid && (byte_count == '0))
  `SFFR_ASSERT_NEXT(a_hunt_drop,
    in_xfer && (byte_count == '0) && (rx.rx_byte != sffr_pkg::HDR_BYTE),
    byte_count == '0)
  `SFFR_ASSERT_NOW(a_reject_zero,
    out_valid && (out_status != sffr_pkg::ST_OK),
    !out_slot && (out_qty == '0) && (out_reading == '0))

endmodule
